// File: design/psq_pkg.sv
package psq_pkg;

  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int LEN_W = 7;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_LENGTH = 2'd3
  } psq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } psq_status_t;

  typedef struct packed {
    logic             shift_ins;
    logic             shift_rem;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] new_val;
  } psq_ctrl_t;

endpackage

// File: design/positional_sequence_store.sv
// Results: a result appears on the output ports in the cycle after its item is accepted.
// Throughput: one item per cycle while busy is low; every cell that moves shifts in the same cycle,
// and the read path is one selection over the first 64 cells.
// Reset: synchronous, active low; the length clears and busy is set, then clears once reset is released.
// The receiver cannot stall: each result is shown for exactly one cycle.
module positional_sequence_store #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_cmd,
  input  logic [psq_pkg::POS_W-1:0]          in_position,
  input  logic signed [psq_pkg::VAL_W-1:0]   in_new_value,
  output logic                               out_strobe,
  output logic signed [psq_pkg::VAL_W-1:0]   out_item_value,
  output logic [psq_pkg::LEN_W-1:0]          out_length_now,
  output logic [1:0]                         out_status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > psq_pkg::POS_W) ? CW : psq_pkg::POS_W;
  localparam int NR = 1 << psq_pkg::POS_W;

  psq_pkg::psq_ctrl_t          cell_ctrl;
  logic [psq_pkg::VAL_W-1:0]   cell_val [CAPACITY];
  logic [psq_pkg::VAL_W-1:0]   rd_arr   [NR];
  logic [psq_pkg::VAL_W-1:0]   rd_data;
  logic [psq_pkg::VAL_W-1:0]   out_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [psq_pkg::VAL_W-1:0] left_val;
    logic [psq_pkg::VAL_W-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end
    psq_cell #(.IW(PW), .IDX(i)) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[i])
    );
  end

  for (genvar j = 0; j < NR; j++) begin : g_rd
    if (j < CAPACITY) begin : g_used
      assign rd_arr[j] = cell_val[j];
    end else begin : g_none
      assign rd_arr[j] = '0;
    end
  end

  assign rd_data = rd_arr[in_position];

  psq_ctrl #(.CAPACITY(CAPACITY), .CW(CW), .PW(PW)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_cmd       (in_cmd),
    .in_position  (in_position),
    .in_new_value (in_new_value),
    .rd_data      (rd_data),
    .cell_ctrl    (cell_ctrl),
    .busy         (busy),
    .out_strobe   (out_strobe),
    .out_value    (out_value),
    .out_length   (out_length_now),
    .out_status   (out_status)
  );

  assign out_item_value = out_value;

endmodule

// File: design/psq_cell.sv
module psq_cell #(
  parameter int IW  = 7,
  parameter int IDX = 0
) (
  input  logic                           clk,
  input  psq_pkg::psq_ctrl_t             ctrl,
  input  logic [psq_pkg::VAL_W-1:0]      left_val,
  input  logic [psq_pkg::VAL_W-1:0]      right_val,
  output logic [psq_pkg::VAL_W-1:0]      val
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [psq_pkg::VAL_W-1:0] val_r;
  logic [psq_pkg::VAL_W-1:0] val_nxt;
  logic [IW-1:0]             pos_w;

  always_comb begin
    pos_w   = IW'(ctrl.pos);
    val_nxt = val_r;
    if (ctrl.shift_ins) begin
      if (MY_IDX > pos_w) begin
        val_nxt = left_val;
      end else if (MY_IDX == pos_w) begin
        val_nxt = ctrl.new_val;
      end
    end else if (ctrl.shift_rem) begin
      if (MY_IDX >= pos_w) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// File: design/psq_ctrl.sv
module psq_ctrl #(
  parameter int CAPACITY = 64,
  parameter int CW       = 7,
  parameter int PW       = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [1:0]                    in_cmd,
  input  logic [psq_pkg::POS_W-1:0]     in_position,
  input  logic [psq_pkg::VAL_W-1:0]     in_new_value,
  input  logic [psq_pkg::VAL_W-1:0]     rd_data,
  output psq_pkg::psq_ctrl_t            cell_ctrl,
  output logic                          busy,
  output logic                          out_strobe,
  output logic [psq_pkg::VAL_W-1:0]     out_value,
  output logic [psq_pkg::LEN_W-1:0]     out_length,
  output logic [1:0]                    out_status
);

  logic                         busy_r;
  logic                         strobe_r;
  logic                         strobe_nxt;
  logic [CW-1:0]                count_r;
  logic [CW-1:0]                count_nxt;
  logic [psq_pkg::VAL_W-1:0]    value_r;
  logic [psq_pkg::VAL_W-1:0]    value_nxt;
  psq_pkg::psq_status_t         status_r;
  psq_pkg::psq_status_t         status_nxt;
  logic                         acc;
  psq_pkg::psq_cmd_t            cmd_e;
  logic [PW-1:0]                pos_w;
  logic [PW-1:0]                cnt_w;

  always_comb begin
    acc        = start && !busy_r;
    cmd_e      = psq_pkg::psq_cmd_t'(in_cmd);
    pos_w      = PW'(in_position);
    cnt_w      = PW'(count_r);
    cell_ctrl  = '{shift_ins: 1'b0, shift_rem: 1'b0, pos: in_position, new_val: in_new_value};
    count_nxt  = count_r;
    value_nxt  = value_r;
    status_nxt = status_r;
    strobe_nxt = acc;
    if (acc) begin
      value_nxt  = '0;
      status_nxt = psq_pkg::ST_OK;
      unique case (cmd_e)
        psq_pkg::CMD_READ: begin
          if (pos_w >= cnt_w) begin
            status_nxt = psq_pkg::ST_RANGE;
          end else begin
            value_nxt = rd_data;
          end
        end
        psq_pkg::CMD_INSERT: begin
          if (pos_w > cnt_w) begin
            status_nxt = psq_pkg::ST_RANGE;
          end else if (count_r == CW'(CAPACITY)) begin
            status_nxt = psq_pkg::ST_FULL;
          end else begin
            cell_ctrl.shift_ins = 1'b1;
            count_nxt           = count_r + 1'b1;
          end
        end
        psq_pkg::CMD_REMOVE: begin
          if (pos_w >= cnt_w) begin
            status_nxt = psq_pkg::ST_RANGE;
          end else begin
            value_nxt           = rd_data;
            cell_ctrl.shift_rem = 1'b1;
            count_nxt           = count_r - 1'b1;
          end
        end
        psq_pkg::CMD_LENGTH: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      strobe_r <= 1'b0;
      count_r  <= '0;
    end else begin
      busy_r   <= 1'b0;
      strobe_r <= strobe_nxt;
      count_r  <= count_nxt;
    end
    value_r  <= value_nxt;
    status_r <= status_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;
  assign out_value  = value_r;
  assign out_length = psq_pkg::LEN_W'(count_r);
  assign out_status = status_r;

endmodule

// File: design/psq_checker.sv
module psq_props (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [1:0]                        in_cmd,
  input logic                              out_strobe,
  input logic signed [psq_pkg::VAL_W-1:0]  out_item_value,
  input logic [1:0]                        out_status
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_strobe)
    else $error("accepted item gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_strobe)
    else $error("result without an accepted item");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != psq_pkg::ST_OK) |-> out_item_value == 0)
    else $error("rejected item returned a value");

  a_len_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == psq_pkg::CMD_LENGTH) |=>
      (out_status == psq_pkg::ST_OK && out_item_value == 0))
    else $error("length item returned value or error");

endmodule

bind positional_sequence_store psq_props u_psq_props (.*);

// File: sim/psq_checker.sv
`timescale 1ns / 100ps

module psq_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic [1:0]                       in_cmd,
  input  logic [psq_pkg::POS_W-1:0]        in_position,
  input  logic signed [psq_pkg::VAL_W-1:0] in_new_value,
  input  logic                             out_strobe,
  input  logic signed [psq_pkg::VAL_W-1:0] out_item_value,
  input  logic [psq_pkg::LEN_W-1:0]        out_length_now,
  input  logic [1:0]                       out_status,
  output int                               fail_count,
  output int                               pending
);

  typedef struct packed {
    logic signed [psq_pkg::VAL_W-1:0] value;
    logic [psq_pkg::LEN_W-1:0]        length;
    logic [1:0]                       status;
  } psq_result_t;

  logic signed [psq_pkg::VAL_W-1:0] seq_vals [CAPACITY];
  int unsigned                      seq_len = 0;
  psq_result_t                      result_q [$];
  int                               mismatches = 0;
  int                               waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  function automatic psq_result_t apply_command(psq_pkg::psq_cmd_t cmd,
                                                logic [psq_pkg::POS_W-1:0] pos,
                                                logic signed [psq_pkg::VAL_W-1:0] val);
    psq_result_t r;
    int          i;
    r.value  = '0;
    r.status = psq_pkg::ST_OK;
    case (cmd)
      psq_pkg::CMD_READ: begin
        if (pos >= seq_len) r.status = psq_pkg::ST_RANGE;
        else r.value = seq_vals[pos];
      end
      psq_pkg::CMD_INSERT: begin
        if (pos > seq_len) r.status = psq_pkg::ST_RANGE;
        else if (seq_len >= CAPACITY) r.status = psq_pkg::ST_FULL;
        else begin
          for (i = seq_len; i > pos; i--) seq_vals[i] = seq_vals[i-1];
          seq_vals[pos] = val;
          seq_len++;
        end
      end
      psq_pkg::CMD_REMOVE: begin
        if (pos >= seq_len) r.status = psq_pkg::ST_RANGE;
        else begin
          r.value = seq_vals[pos];
          for (i = pos; i + 1 < seq_len; i++) seq_vals[i] = seq_vals[i+1];
          seq_len--;
        end
      end
      default: ;
    endcase
    r.length = seq_len[psq_pkg::LEN_W-1:0];
    return r;
  endfunction

  task automatic flag(string what, psq_result_t exp_r, psq_result_t got_r);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected value %0d length %0d status %0d, %s %0d length %0d status %0d",
               $realtime, what, exp_r.value, exp_r.length, exp_r.status, "got value",
               got_r.value, got_r.length, got_r.status);
  endtask

  always @(posedge clk) begin
    psq_result_t got_r;
    psq_result_t exp_r;
    if (!rst_n) begin
      seq_len = 0;
      result_q.delete();
    end else begin
      if (out_strobe) begin
        got_r.value  = out_item_value;
        got_r.length = out_length_now;
        got_r.status = out_status;
        if (result_q.size() == 0) begin
          flag("result with nothing outstanding", '0, got_r);
        end else begin
          exp_r = result_q.pop_front();
          if (got_r.value !== exp_r.value) flag("item_value mismatch", exp_r, got_r);
          else if (got_r.length !== exp_r.length) flag("length_now mismatch", exp_r, got_r);
          else if (got_r.status !== exp_r.status) flag("status mismatch", exp_r, got_r);
        end
      end
      if (start && !busy)
        result_q.push_back(apply_command(psq_pkg::psq_cmd_t'(in_cmd), in_position,
                                         in_new_value));
    end
    waiting = result_q.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 1050;

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  logic [1:0]                       in_cmd;
  logic [psq_pkg::POS_W-1:0]        in_position;
  logic signed [psq_pkg::VAL_W-1:0] in_new_value;
  logic                             out_strobe;
  logic signed [psq_pkg::VAL_W-1:0] out_item_value;
  logic [psq_pkg::LEN_W-1:0]        out_length_now;
  logic [1:0]                       out_status;
  int                               fail_count;
  int                               pending;
  int                               len_guess;
  bit                               idle_on;

  positional_sequence_store #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_position(in_position), .in_new_value(in_new_value),
    .out_strobe(out_strobe), .out_item_value(out_item_value),
    .out_length_now(out_length_now), .out_status(out_status)
  );

  psq_checker #(.CAPACITY(CAPACITY)) store_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_position(in_position), .in_new_value(in_new_value),
    .out_strobe(out_strobe), .out_item_value(out_item_value),
    .out_length_now(out_length_now), .out_status(out_status),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_item(psq_pkg::psq_cmd_t cmd, logic [psq_pkg::POS_W-1:0] pos,
                           logic signed [psq_pkg::VAL_W-1:0] val);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_position  <= pos;
    in_new_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (cmd)
      psq_pkg::CMD_INSERT: if (pos <= len_guess && len_guess < CAPACITY) len_guess++;
      psq_pkg::CMD_REMOVE: if (pos < len_guess) len_guess--;
      default: ;
    endcase
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int                        n;
    int                        pick;
    int                        draw;
    bit                        growing;
    bit                        noise;
    psq_pkg::psq_cmd_t         cmd;
    logic [psq_pkg::POS_W-1:0] pos;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_cmd       = '0;
    in_position  = '0;
    in_new_value = '0;
    len_guess    = 0;
    idle_on      = 1'b1;
    growing      = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty store: every read, remove and insert out of range
    send_item(psq_pkg::CMD_LENGTH, 6'd0, 32'sd0);
    send_item(psq_pkg::CMD_READ, 6'd0, 32'sd0);
    send_item(psq_pkg::CMD_REMOVE, 6'd0, 32'sd0);
    send_item(psq_pkg::CMD_INSERT, 6'd1, 32'sd5);
    // front, append, middle and out-of-range inserts with extreme values
    send_item(psq_pkg::CMD_INSERT, 6'd0, 32'sh7FFF_FFFF);
    send_item(psq_pkg::CMD_INSERT, 6'd1, 32'sh8000_0000);
    send_item(psq_pkg::CMD_INSERT, 6'd0, -32'sd1);
    send_item(psq_pkg::CMD_INSERT, 6'd1, 32'sd0);
    send_item(psq_pkg::CMD_INSERT, 6'd5, 32'sd9);
    for (n = 0; n < 4; n++) send_item(psq_pkg::CMD_READ, n[psq_pkg::POS_W-1:0], 32'sd0);
    send_item(psq_pkg::CMD_READ, 6'd4, 32'sd0);
    send_item(psq_pkg::CMD_READ, 6'd63, 32'sh7FFF_FFFF);
    send_item(psq_pkg::CMD_REMOVE, 6'd1, 32'sd0);
    send_item(psq_pkg::CMD_REMOVE, 6'd2, 32'sd0);
    send_item(psq_pkg::CMD_REMOVE, 6'd0, 32'sd0);
    send_item(psq_pkg::CMD_LENGTH, 6'd63, $urandom);
    send_item(psq_pkg::CMD_INSERT, 6'd1, 32'sh5555_5555);
    send_item(psq_pkg::CMD_READ, 6'd1, 32'sd0);
    send_item(psq_pkg::CMD_REMOVE, 6'd1, 32'sd0);
    send_item(psq_pkg::CMD_REMOVE, 6'd0, 32'sd0);
    send_item(psq_pkg::CMD_LENGTH, 6'd0, 32'sd0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (len_guess >= CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (len_guess == 0) growing = 1'b1;
      if ($urandom_range(0, 99) == 0) growing = ~growing;
      noise = ($urandom_range(0, 99) < 8);
      pick  = $urandom_range(0, 99);
      if (growing)
        cmd = pick < 55 ? psq_pkg::CMD_INSERT : pick < 75 ? psq_pkg::CMD_READ :
              pick < 90 ? psq_pkg::CMD_REMOVE : psq_pkg::CMD_LENGTH;
      else
        cmd = pick < 55 ? psq_pkg::CMD_REMOVE : pick < 70 ? psq_pkg::CMD_INSERT :
              pick < 90 ? psq_pkg::CMD_READ : psq_pkg::CMD_LENGTH;
      if (noise || cmd == psq_pkg::CMD_LENGTH)
        draw = $urandom_range(0, 63);
      else if (cmd == psq_pkg::CMD_INSERT)
        draw = $urandom_range(0, len_guess > 63 ? 63 : len_guess);
      else
        draw = len_guess > 0 ? $urandom_range(0, len_guess - 1) : 0;
      pos = draw[psq_pkg::POS_W-1:0];
      send_item(cmd, pos, $urandom);
    end

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
design/psq_pkg.sv
design/psq_cell.sv
design/psq_ctrl.sv
design/positional_sequence_store.sv
design/psq_checker.sv
sim/psq_checker.sv
sim/testbench.sv
